FILE: hw/rtl/move_machine_core_assert.svh
// Assertion macros for the checker file.
`ifndef MOVE_MACHINE_CORE_ASSERT_SVH
`define MOVE_MACHINE_CORE_ASSERT_SVH

// Check a property outside reset.
`define MMC_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property at every edge, reset included.
`define MMC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: hw/rtl/mmc_pkg.sv
package mmc_pkg;

    localparam int ROM_WORDS = 256;
    localparam int RAM_WORDS = 65024;
    localparam int WORD_BITS = 16;
    localparam int ROM_AW    = $clog2(ROM_WORDS);
    localparam int RAM_AW    = $clog2(RAM_WORDS);

    // memory map
    localparam logic [WORD_BITS-1:0] A_PC       = 16'hFFFF;
    localparam logic [WORD_BITS-1:0] A_PC_CARRY = 16'hFFFE;
    localparam logic [WORD_BITS-1:0] A_PC_SIGN  = 16'hFFFD;
    localparam logic [WORD_BITS-1:0] A_PC_ZERO  = 16'hFFFC;
    localparam logic [WORD_BITS-1:0] A_ADD      = 16'hFFFB;
    localparam logic [WORD_BITS-1:0] A_ADD_INC  = 16'hFFFA;
    localparam logic [WORD_BITS-1:0] A_REG_B    = 16'hFFF9;
    localparam logic [WORD_BITS-1:0] A_REG_A    = 16'hFFF8;
    localparam logic [WORD_BITS-1:0] A_ACC      = 16'hFFF7;
    localparam logic [WORD_BITS-1:0] A_OUT1     = 16'hFFF6;
    localparam logic [WORD_BITS-1:0] A_IN1      = 16'hFFF5;
    localparam logic [WORD_BITS-1:0] A_OUT2     = 16'hFFF4;
    localparam logic [WORD_BITS-1:0] A_IN2      = 16'hFFF3;
    localparam logic [WORD_BITS-1:0] A_XOR      = 16'hFFEF;
    localparam logic [WORD_BITS-1:0] A_OR       = 16'hFFEE;
    localparam logic [WORD_BITS-1:0] A_AND      = 16'hFFED;
    localparam logic [WORD_BITS-1:0] A_NOT      = 16'hFFEC;
    localparam logic [WORD_BITS-1:0] RAM_LO     = 16'h0100;
    localparam logic [WORD_BITS-1:0] RAM_HI     = 16'hFEFF;

    localparam logic CMD_STEP = 1'b0;
    localparam logic CMD_LOAD = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_DST  = 4'b0010,
        S_SRC  = 4'b0100,
        S_EXEC = 4'b1000
    } t_state;

    // first member sits in the highest bits
    typedef struct packed {
        logic [WORD_BITS-1:0] input_port_two;
        logic [WORD_BITS-1:0] input_port_one;
        logic [WORD_BITS-1:0] rom_word;
        logic [7:0]           rom_index;
    } t_in_data;

    typedef struct packed {
        logic [WORD_BITS-1:0] moved_to;
        logic [WORD_BITS-1:0] moved_value;
        logic [WORD_BITS-1:0] next_pc;
        logic [WORD_BITS-1:0] output_port_two;
        logic [WORD_BITS-1:0] output_port_one;
    } t_out_data;

endpackage

FILE: hw/rtl/mmc_ram.sv
module mmc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hw/rtl/move_machine_core.sv
// Move processor: every step fetches a source and a destination word at the
// program counter, reads the source and writes the value to the destination.
// Slave channel: tuser carries the command (0 step, 1 load one ROM word);
// tdata carries rom_index, rom_word and the two input port values.
// Master channel: one transfer per accepted item with both output port
// registers, the program counter after the item, the moved value and the
// destination address (both zero for a load).
// A step issues three dependent reads through the registered-read ROM/RAM
// ports (instruction source word, destination word, source operand) in the
// states IDLE, DST and SRC, and writes back in EXEC. A load is done in IDLE.
// A one-entry input buffer takes the next item while a step is in work, and
// the result register lets the next step start while a result waits.
// When the receiver stalls, the block finishes the current item, holds it in
// its final state until the result register frees, and stops taking input once the input buffer is full.
// Reset clears the program counter, operand, accumulator and output registers
// and all handshake state; ROM and RAM contents are undefined until written.
module move_machine_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic        i_s_axis_tuser,   // command
    // rom_index[7:0], rom_word[23:8], input_port_one[39:24], input_port_two[55:40]
    input  logic [55:0] i_s_axis_tdata,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // output_port_one[15:0], output_port_two[31:16], next_pc[47:32],
    // moved_value[63:48], moved_to[79:64]
    output logic [79:0] o_m_axis_tdata
);

    localparam int WB = mmc_pkg::WORD_BITS;

    function automatic logic rom_hit(input logic [WB-1:0] addr);
        return addr < WB'(mmc_pkg::ROM_WORDS);
    endfunction

    function automatic logic ram_hit(input logic [WB-1:0] addr);
        logic [WB-1:0] off;
        off = addr - mmc_pkg::RAM_LO;
        return (addr >= mmc_pkg::RAM_LO) && (addr <= mmc_pkg::RAM_HI)
            && (off < WB'(mmc_pkg::RAM_WORDS));
    endfunction

    mmc_pkg::t_state    r_state, n_state;
    logic               r_ibuf_vld;
    logic               r_ibuf_cmd;
    mmc_pkg::t_in_data  r_ibuf;
    logic [WB-1:0]      r_pc, n_pc;
    logic [WB-1:0]      r_a, n_a;
    logic [WB-1:0]      r_b, n_b;
    logic [WB-1:0]      r_acc, n_acc;
    logic [WB-1:0]      r_out1, n_out1;
    logic [WB-1:0]      r_out2, n_out2;
    logic [WB-1:0]      r_in1, r_in2;
    logic [WB-1:0]      r_raddr;
    logic [WB-1:0]      r_src, r_dst;
    logic               r_out_vld;
    mmc_pkg::t_out_data r_out, n_out;

    logic          s_accept;
    logic          out_free;
    logic          step_start;
    logic          load_fire;
    logic          exec_fire;
    logic          ibuf_take;
    logic          iss_en;
    logic [WB-1:0] iss_addr;
    logic [WB-1:0] iss_off;
    logic [WB-1:0] dst_off;
    logic [WB:0]   sum;
    logic [WB-1:0] rd_data;
    logic [WB-1:0] rom_dout, ram_dout;
    logic          rom_we, ram_we;

    assign out_free   = !r_out_vld || i_m_axis_tready;
    assign step_start = (r_state == mmc_pkg::S_IDLE) && r_ibuf_vld
                        && (r_ibuf_cmd == mmc_pkg::CMD_STEP);
    assign load_fire  = (r_state == mmc_pkg::S_IDLE) && r_ibuf_vld
                        && (r_ibuf_cmd == mmc_pkg::CMD_LOAD) && out_free;
    assign exec_fire  = (r_state == mmc_pkg::S_EXEC) && out_free;
    assign ibuf_take  = step_start || load_fire;

    assign o_s_axis_tready = !r_ibuf_vld || ibuf_take;
    assign s_accept        = i_s_axis_tvalid && o_s_axis_tready;

    // read issue: instruction word at pc, then pc + 1, then the source
    assign iss_en   = step_start || (r_state == mmc_pkg::S_DST)
                      || (r_state == mmc_pkg::S_SRC);
    always_comb begin
        if (r_state == mmc_pkg::S_DST) begin
            iss_addr = r_pc + WB'(1);
        end else if (r_state == mmc_pkg::S_SRC) begin
            iss_addr = r_src;
        end else begin
            iss_addr = r_pc;
        end
    end
    assign iss_off = iss_addr - mmc_pkg::RAM_LO;
    assign dst_off = r_dst - mmc_pkg::RAM_LO;

    assign rom_we = load_fire && ({1'b0, r_ibuf.rom_index} < 9'(mmc_pkg::ROM_WORDS));
    assign ram_we = exec_fire && ram_hit(r_dst);

    mmc_ram #(
        .WIDTH(WB),
        .DEPTH(mmc_pkg::ROM_WORDS)
    ) u_rom (
        .i_clk  (i_clk),
        .i_we   (rom_we),
        .i_waddr(r_ibuf.rom_index[mmc_pkg::ROM_AW-1:0]),
        .i_wdata(r_ibuf.rom_word),
        .i_re   (iss_en && rom_hit(iss_addr)),
        .i_raddr(iss_addr[mmc_pkg::ROM_AW-1:0]),
        .o_rdata(rom_dout)
    );

    mmc_ram #(
        .WIDTH(WB),
        .DEPTH(mmc_pkg::RAM_WORDS)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(dst_off[mmc_pkg::RAM_AW-1:0]),
        .i_wdata(rd_data),
        .i_re   (iss_en && ram_hit(iss_addr)),
        .i_raddr(iss_off[mmc_pkg::RAM_AW-1:0]),
        .o_rdata(ram_dout)
    );

    assign sum = {1'b0, r_a} + {1'b0, r_b};

    // bus read result for the most recently issued address
    always_comb begin
        unique case (r_raddr)
            mmc_pkg::A_ADD:     rd_data = sum[WB-1:0];
            mmc_pkg::A_ADD_INC: rd_data = sum[WB-1:0] + WB'(1);
            mmc_pkg::A_IN1:     rd_data = r_in1;
            mmc_pkg::A_IN2:     rd_data = r_in2;
            mmc_pkg::A_XOR:     rd_data = r_a ^ r_b;
            mmc_pkg::A_OR:      rd_data = r_a | r_b;
            mmc_pkg::A_AND:     rd_data = r_a & r_b;
            mmc_pkg::A_NOT:     rd_data = ~r_a;
            mmc_pkg::A_ACC:     rd_data = r_acc;
            default: begin
                if (rom_hit(r_raddr)) begin
                    rd_data = rom_dout;
                end else if (ram_hit(r_raddr)) begin
                    rd_data = ram_dout;
                end else begin
                    rd_data = '0;
                end
            end
        endcase
    end

    // write back at the end of a step, and the result word for a step or a load
    always_comb begin
        n_pc   = r_pc;
        n_a    = r_a;
        n_b    = r_b;
        n_acc  = r_acc;
        n_out1 = r_out1;
        n_out2 = r_out2;
        if (exec_fire) begin
            n_pc = r_pc + WB'(2);
            unique case (r_dst)
                mmc_pkg::A_PC:       n_pc = rd_data;
                mmc_pkg::A_PC_CARRY: if (sum[WB]) n_pc = rd_data;
                mmc_pkg::A_PC_SIGN:  if (r_acc[WB-1]) n_pc = rd_data;
                mmc_pkg::A_PC_ZERO:  if (r_acc == '0) n_pc = rd_data;
                mmc_pkg::A_REG_B:    n_b = rd_data;
                mmc_pkg::A_REG_A:    n_a = rd_data;
                mmc_pkg::A_ACC:      n_acc = rd_data;
                mmc_pkg::A_OUT1:     n_out1 = rd_data;
                mmc_pkg::A_OUT2:     n_out2 = rd_data;
                default: ;
            endcase
        end
        n_out.output_port_one = n_out1;
        n_out.output_port_two = n_out2;
        n_out.next_pc         = n_pc;
        n_out.moved_value     = exec_fire ? rd_data : '0;
        n_out.moved_to        = exec_fire ? r_dst : '0;
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            mmc_pkg::S_IDLE: if (step_start) n_state = mmc_pkg::S_DST;
            mmc_pkg::S_DST:  n_state = mmc_pkg::S_SRC;
            mmc_pkg::S_SRC:  n_state = mmc_pkg::S_EXEC;
            mmc_pkg::S_EXEC: if (exec_fire) n_state = mmc_pkg::S_IDLE;
            default:         n_state = mmc_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= mmc_pkg::S_IDLE;
            r_ibuf_vld <= 1'b0;
            r_out_vld  <= 1'b0;
            r_pc       <= '0;
            r_a        <= '0;
            r_b        <= '0;
            r_acc      <= '0;
            r_out1     <= '0;
            r_out2     <= '0;
        end else begin
            r_state <= n_state;
            r_pc    <= n_pc;
            r_a     <= n_a;
            r_b     <= n_b;
            r_acc   <= n_acc;
            r_out1  <= n_out1;
            r_out2  <= n_out2;
            if (s_accept) begin
                r_ibuf_vld <= 1'b1;
            end else if (ibuf_take) begin
                r_ibuf_vld <= 1'b0;
            end
            if (exec_fire || load_fire) begin
                r_out_vld <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_ibuf_cmd <= i_s_axis_tuser;
            r_ibuf     <= mmc_pkg::t_in_data'(i_s_axis_tdata);
        end
        if (step_start) begin
            r_in1 <= r_ibuf.input_port_one;
            r_in2 <= r_ibuf.input_port_two;
        end
        if (iss_en) begin
            r_raddr <= iss_addr;
        end
        if (r_state == mmc_pkg::S_DST) begin
            r_src <= rd_data;
        end
        if (r_state == mmc_pkg::S_SRC) begin
            r_dst <= rd_data;
        end
        if (exec_fire || load_fire) begin
            r_out <= n_out;
        end
    end

    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tdata  = r_out;

endmodule

FILE: hw/rtl/mmc_chk.sv
`include "move_machine_core_assert.svh"

module mmc_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic [79:0] o_m_axis_tdata
);

    logic        m_vld;
    logic        m_xfer;
    logic        m_stall;
    logic [79:0] m_data;
    logic [15:0] m_out1, m_out2, m_pc, m_val, m_to;
    logic        to_out1, to_out2, to_pc;

    assign m_vld   = o_m_axis_tvalid;
    assign m_data  = o_m_axis_tdata;
    assign m_xfer  = o_m_axis_tvalid && i_m_axis_tready;
    assign m_stall = o_m_axis_tvalid && !i_m_axis_tready;
    assign m_out1  = o_m_axis_tdata[15:0];
    assign m_out2  = o_m_axis_tdata[31:16];
    assign m_pc    = o_m_axis_tdata[47:32];
    assign m_val   = o_m_axis_tdata[63:48];
    assign m_to    = o_m_axis_tdata[79:64];
    assign to_out1 = m_xfer && (m_to == mmc_pkg::A_OUT1);
    assign to_out2 = m_xfer && (m_to == mmc_pkg::A_OUT2);
    assign to_pc   = m_xfer && (m_to == mmc_pkg::A_PC);

    `MMC_ASSERT_ALWAYS(a_rst_idle, i_clk, !i_rst_n |=> !m_vld, "result valid after reset")
    `MMC_ASSERT(a_hold, i_clk, i_rst_n, m_stall |=> m_vld && $stable(m_data), "held result changed")
    `MMC_ASSERT(a_out1, i_clk, i_rst_n, to_out1 |-> m_out1 == m_val, "port one mismatch")
    `MMC_ASSERT(a_out2, i_clk, i_rst_n, to_out2 |-> m_out2 == m_val, "port two mismatch")
    `MMC_ASSERT(a_jump, i_clk, i_rst_n, to_pc |-> m_pc == m_val, "jump target not taken")

endmodule

bind move_machine_core mmc_chk u_mmc_chk (.*);
